>>> rtl/core/polygon_area_perimeter_circularity_macros.svh
// Assertion helpers for the polygon measurement block.
// Each helper is clocked on clk_i and disabled while rst_ni is low.
`ifndef POLYGON_AREA_PERIMETER_CIRCULARITY_MACROS_SVH
`define POLYGON_AREA_PERIMETER_CIRCULARITY_MACROS_SVH

`ifndef SYNTHESIS
`define PAPC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("papc assertion failed");
`define PAPC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("papc assertion failed");
`else
`define PAPC_ASSERT(label, prop)
`define PAPC_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> rtl/core/papc_pkg.sv
package papc_pkg;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned CrossBits  = 38;
  localparam int unsigned LenBits    = 40;
  localparam int unsigned AreaBits   = 26;
  localparam int unsigned PerimBits  = 32;
  localparam int unsigned CircBits   = 24;
  localparam int unsigned RootBits   = 21;
  localparam int unsigned RadBits    = 2 * RootBits;
  localparam int unsigned DivSteps   = 29;
  localparam int unsigned CntBits    = 5;
  localparam logic [31:0] TwoPiQ29   = 32'd3373259426;

  typedef struct packed {
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic                        last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [AreaBits-1:0]  twice_area;
    logic [PerimBits-1:0] perimeter_q8;
    logic [CircBits-1:0]  circularity_q16;
    logic                 degenerate;
  } result_t;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CROSS_A, OP_CROSS_B, OP_SQ_A, OP_SQ_B, OP_SQRT,
    OP_ACC, OP_FIN, OP_MUL_N, OP_MUL_D, OP_CHECK, OP_DIV, OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic close;
  } cmd_t;

  typedef struct packed {
    logic in_poly;
    logic last;
    logic sat;
  } status_t;

endpackage

>>> rtl/core/polygon_area_perimeter_circularity.sv
// Polygon area, perimeter and circularity.
// Input channel: one vertex per beat (x, y, last flag) on in_valid_i with
// in_stall_o. Output channel: one result per polygon on out_valid_o with
// out_stall_i, carrying twice the area, the perimeter in Q24.8, the
// circularity in Q8.16 and a flag for zero area.
// Each edge runs the cross products (S_CA, S_CB), the squared deltas
// (S_QA, S_QB) and 21 square-root digit steps on a shared unit, then the
// accumulation (S_ACC). A plain vertex is accepted and then runs its edge;
// the first vertex of a polygon, unless it is also the last, is only loaded.
// The last vertex adds its closing edge, a step to clamp the sums (S_FIN),
// the multiplier steps (S_MN, S_MD), a check, 29 restoring division steps
// and a step to load the result register (S_OUT). When the circularity
// saturates at the check, the division steps are skipped. The next vertex
// can be accepted in the cycle the result beat first shows.
// The result register decouples the output; a stalled result holds while the
// next polygon's vertices are accepted, and only the next result waits.
// Reset clears the controller and the polygon flag; the next vertex starts
// a new polygon.
module polygon_area_perimeter_circularity (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  papc_pkg::vertex_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output papc_pkg::result_t  out_data_o
);
  import papc_pkg::*;

  cmd_t    cmd;
  status_t status;

  papc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_vertex),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  papc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .vertex_i (in_data_i),
    .status_o (status),
    .result_o (out_data_o)
  );

endmodule

>>> rtl/core/papc_dp.sv
module papc_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  papc_pkg::cmd_t   cmd_i,
  input  papc_pkg::vertex_t vertex_i,
  output papc_pkg::status_t status_o,
  output papc_pkg::result_t result_o
);
  import papc_pkg::*;

  logic                        in_poly_q;
  logic                        last_q;
  logic signed [CoordBits-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CoordBits-1:0] cur_x_q, cur_y_q;
  logic [CrossBits-1:0]        cross_q;
  logic [LenBits-1:0]          len_q;
  logic [24:0]                 sq_q;
  logic [RadBits-1:0]          rad_q;
  logic [RootBits+1:0]         rem_q;
  logic [RootBits-1:0]         root_q;
  logic [AreaBits-1:0]         t_q;
  logic [PerimBits-1:0]        p_q;
  logic [63:0]                 n_q;
  logic [57:0]                 d_q;
  logic [57:0]                 r_q;
  logic [DivSteps-1:0]         quo_q;
  logic                        sat_q;
  result_t                     out_q;

  // Edge end points: walking edge or closing edge.
  logic signed [CoordBits:0] ex1, ey1, ex2, ey2, dx, dy;
  assign ex1 = cmd_i.close ? (CoordBits+1)'(cur_x_q) : (CoordBits+1)'(prev_x_q);
  assign ey1 = cmd_i.close ? (CoordBits+1)'(cur_y_q) : (CoordBits+1)'(prev_y_q);
  assign ex2 = cmd_i.close ? (CoordBits+1)'(first_x_q) : (CoordBits+1)'(cur_x_q);
  assign ey2 = cmd_i.close ? (CoordBits+1)'(first_y_q) : (CoordBits+1)'(cur_y_q);
  assign dx  = ex2 - ex1;
  assign dy  = ey2 - ey1;

  // Shared small signed multiplier for cross terms and squares.
  logic signed [CoordBits:0]     ma, mb;
  logic signed [2*CoordBits+1:0] sprod;
  always_comb begin
    case (cmd_i.op)
      OP_CROSS_A: begin ma = ex1; mb = ey2; end
      OP_CROSS_B: begin ma = ey1; mb = ex2; end
      OP_SQ_A:    begin ma = dx;  mb = dx;  end
      default:    begin ma = dy;  mb = dy;  end
    endcase
  end
  assign sprod = (2*CoordBits+2)'(ma) * (2*CoordBits+2)'(mb);

  logic [CrossBits-1:0] sprod_ext;
  assign sprod_ext = {{(CrossBits-2*CoordBits-2){sprod[2*CoordBits+1]}}, sprod};

  logic [24:0] sq_sum;
  assign sq_sum = sq_q + sprod[24:0];

  // One digit of the square root: two radicand bits per step.
  logic [RootBits+3:0] rem_t, trial;
  logic                root_ge;
  assign rem_t   = {rem_q, rad_q[RadBits-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign root_ge = rem_t >= trial;

  logic [LenBits:0] len_sum;
  assign len_sum = {1'b0, len_q} + (LenBits+1)'(root_q);

  // Magnitude of the cross sum.
  logic [CrossBits-1:0] cross_mag;
  assign cross_mag = cross_q[CrossBits-1] ? (~cross_q + 1'b1) : cross_q;

  // Shared wide multiplier for P squared and T times two pi.
  logic [31:0] wa, wb;
  logic [63:0] wprod;
  assign wa    = (cmd_i.op == OP_MUL_N) ? p_q : 32'(t_q);
  assign wb    = (cmd_i.op == OP_MUL_N) ? p_q : TwoPiQ29;
  assign wprod = 64'(wa) * 64'(wb);

  // One restoring division step.
  logic [58:0] rs;
  logic [58:0] rs_sub;
  logic        div_ge;
  assign rs     = {r_q, 1'b0};
  assign div_ge = rs >= {1'b0, d_q};
  assign rs_sub = rs - {1'b0, d_q};

  logic [CircBits-1:0] circ;
  assign circ = (sat_q || (quo_q[DivSteps-1:CircBits] != '0)) ? '1 : quo_q[CircBits-1:0];

  // Polygon tracking flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_poly_q <= 1'b0;
    end else if (cmd_i.op == OP_LOAD) begin
      in_poly_q <= 1'b1;
    end else if (cmd_i.op == OP_ACC && cmd_i.close) begin
      in_poly_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cur_x_q <= vertex_i.vertex_x;
        cur_y_q <= vertex_i.vertex_y;
        last_q  <= vertex_i.last_vertex;
        if (!in_poly_q) begin
          first_x_q <= vertex_i.vertex_x;
          first_y_q <= vertex_i.vertex_y;
          prev_x_q  <= vertex_i.vertex_x;
          prev_y_q  <= vertex_i.vertex_y;
          cross_q   <= '0;
          len_q     <= '0;
        end
      end
      OP_CROSS_A: cross_q <= cross_q + sprod_ext;
      OP_CROSS_B: cross_q <= cross_q - sprod_ext;
      OP_SQ_A:    sq_q <= sprod[24:0];
      OP_SQ_B: begin
        rad_q  <= {1'b0, sq_sum, 16'b0};
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_SQRT: begin
        rad_q <= rad_q << 2;
        if (root_ge) begin
          rem_q  <= (RootBits+2)'(rem_t - trial);
          root_q <= {root_q[RootBits-2:0], 1'b1};
        end else begin
          rem_q  <= (RootBits+2)'(rem_t);
          root_q <= {root_q[RootBits-2:0], 1'b0};
        end
      end
      OP_ACC: begin
        len_q <= len_sum[LenBits] ? '1 : len_sum[LenBits-1:0];
        if (!cmd_i.close) begin
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
        end
      end
      OP_FIN: begin
        t_q <= (cross_mag[CrossBits-1:AreaBits] != '0) ? '1 : cross_mag[AreaBits-1:0];
        p_q <= (len_q[LenBits-1:PerimBits] != '0) ? '1 : len_q[PerimBits-1:0];
      end
      OP_MUL_N: n_q <= wprod;
      OP_MUL_D: d_q <= wprod[57:0];
      OP_CHECK: begin
        sat_q <= status_o.sat;
        r_q   <= n_q[57:0];
        quo_q <= '0;
      end
      OP_DIV: begin
        r_q   <= div_ge ? rs_sub[57:0] : rs[57:0];
        quo_q <= {quo_q[DivSteps-2:0], div_ge};
      end
      OP_OUT: begin
        out_q.twice_area      <= t_q;
        out_q.perimeter_q8    <= p_q;
        out_q.circularity_q16 <= circ;
        out_q.degenerate      <= (t_q == '0);
      end
      default: ;
    endcase
  end

  assign status_o.in_poly = in_poly_q;
  assign status_o.last    = last_q;
  assign status_o.sat     = (t_q == '0) || (n_q >= {6'b0, d_q});
  assign result_o         = out_q;

endmodule

>>> rtl/core/papc_ctrl.sv
`include "polygon_area_perimeter_circularity_macros.svh"

module papc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  papc_pkg::status_t status_i,
  output papc_pkg::cmd_t    cmd_o
);
  import papc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CA    = 13'b0000000000010,
    S_CB    = 13'b0000000000100,
    S_QA    = 13'b0000000001000,
    S_QB    = 13'b0000000010000,
    S_SQRT  = 13'b0000000100000,
    S_ACC   = 13'b0000001000000,
    S_FIN   = 13'b0000010000000,
    S_MN    = 13'b0000100000000,
    S_MD    = 13'b0001000000000,
    S_CHK   = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e             state_q, state_d;
  logic               close_q, close_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               accept, fire;

  assign accept = (state_q == S_IDLE) && in_valid_i;
  assign fire   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Next state and datapath command.
  always_comb begin
    state_d     = state_q;
    close_d     = close_q;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NONE;
    cmd_o.close = close_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_LOAD;
          if (status_i.in_poly) begin
            close_d = 1'b0;
            state_d = S_CA;
          end else if (in_last_i) begin
            close_d = 1'b1;
            state_d = S_CA;
          end
        end
      end
      S_CA: begin cmd_o.op = OP_CROSS_A; state_d = S_CB; end
      S_CB: begin cmd_o.op = OP_CROSS_B; state_d = S_QA; end
      S_QA: begin cmd_o.op = OP_SQ_A;    state_d = S_QB; end
      S_QB: begin
        cmd_o.op = OP_SQ_B;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntBits'(RootBits - 1)) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        if (close_q) begin
          state_d = S_FIN;
        end else if (status_i.last) begin
          close_d = 1'b1;
          state_d = S_CA;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FIN: begin cmd_o.op = OP_FIN;   state_d = S_MN; end
      S_MN:  begin cmd_o.op = OP_MUL_N; state_d = S_MD; end
      S_MD:  begin cmd_o.op = OP_MUL_D; state_d = S_CHK; end
      S_CHK: begin
        cmd_o.op = OP_CHECK;
        cnt_d    = '0;
        state_d  = status_i.sat ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntBits'(DivSteps - 1)) state_d = S_OUT;
      end
      S_OUT: begin
        if (fire) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set when a result is loaded, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      close_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      close_q     <= close_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // The digit counters never run past their step count.
  `PAPC_ASSERT(a_sqrt_cnt, (state_q != S_SQRT) || (cnt_q < CntBits'(RootBits)))
  `PAPC_ASSERT(a_div_cnt, (state_q != S_DIV) || (cnt_q < CntBits'(DivSteps)))
  // A loaded result shows as a valid beat in the next cycle.
  `PAPC_ASSERT_NEXT(a_out_shown, fire, out_valid_o)
  // The closing edge is only ever followed by the final result steps.
  `PAPC_ASSERT_NEXT(a_close_fin, (state_q == S_ACC) && close_q, state_q == S_FIN)

endmodule

>>> tb/polygon_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the polygon block, keeps its own running copy of
// the polygon state and compares every result beat with the predicted one.
module polygon_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  papc_pkg::vertex_t in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  papc_pkg::result_t out_data_i,
  output int                errors_o,
  output int                pending_o
);
  import papc_pkg::*;

  localparam logic [63:0] LenMax   = (64'd1 << 40) - 1;
  localparam logic [63:0] AreaMax  = (64'd1 << 26) - 1;
  localparam logic [63:0] PerimMax = 64'hFFFF_FFFF;
  localparam logic [63:0] CircMax  = (64'd1 << 24) - 1;

  // Running polygon state.
  longint             start_x, start_y, last_x, last_y;
  bit                 open_poly;
  logic signed [37:0] shoelace_sum;
  logic [63:0]        side_len_sum;

  result_t expected_results[$];
  int      errors;

  assign errors_o  = errors;
  assign pending_o = expected_results.size();

  // Bitwise integer square root, rounded down.
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // P squared over 2 pi T in Q8.16, by restoring division.
  function automatic logic [63:0] roundness(input logic [63:0] pq, input logic [63:0] t);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] q;
    n = pq * pq;
    q = '0;
    if (t == 0) return CircMax;
    d = t * 64'(TwoPiQ29);
    if (n / d != 0) return CircMax;
    r = n;
    for (int i = 0; i < DivSteps; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 64'd1;
      end
    end
    return (q > CircMax) ? CircMax : q;
  endfunction

  // Adds one side: its cross product to the shoelace sum and its length.
  task automatic add_side(input longint x1, y1, x2, y2);
    longint      c;
    longint      dx;
    longint      dy;
    logic [63:0] sq;
    c  = x1 * y2 - y1 * x2;
    dx = x2 - x1;
    dy = y2 - y1;
    sq = 64'(dx * dx + dy * dy);
    shoelace_sum = shoelace_sum + c[37:0];
    side_len_sum = side_len_sum + floor_root(sq << 16);
    if (side_len_sum > LenMax) side_len_sum = LenMax;
  endtask

  // Takes one accepted vertex; closes the polygon when it is the last.
  task automatic take_vertex(input vertex_t v);
    longint      x;
    longint      y;
    longint      c;
    logic [63:0] t;
    logic [63:0] p;
    result_t     res;
    x = longint'(v.vertex_x);
    y = longint'(v.vertex_y);
    if (!open_poly) begin
      start_x = x;
      start_y = y;
      shoelace_sum = '0;
      side_len_sum = '0;
      open_poly = 1;
    end else begin
      add_side(last_x, last_y, x, y);
    end
    last_x = x;
    last_y = y;
    if (v.last_vertex) begin
      add_side(x, y, start_x, start_y);
      open_poly = 0;
      c = longint'(shoelace_sum);
      t = (c < 0) ? 64'(-c) : 64'(c);
      if (t > AreaMax) t = AreaMax;
      p = (side_len_sum > PerimMax) ? PerimMax : side_len_sum;
      res.twice_area      = t[AreaBits-1:0];
      res.perimeter_q8    = p[PerimBits-1:0];
      res.circularity_q16 = CircBits'(roundness(p, t));
      res.degenerate      = (t == 0);
      expected_results = {expected_results, res};
    end
  endtask

  // Prediction on input beats, comparison on output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      open_poly = 0;
      start_x = 0; start_y = 0; last_x = 0; last_y = 0;
      shoelace_sum = '0;
      side_len_sum = '0;
      errors = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) take_vertex(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data_i);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.twice_area !== want.twice_area) begin
            $display("%0t: twice_area expected %0d actual %0d", $time,
                     want.twice_area, out_data_i.twice_area);
            errors++;
          end
          if (out_data_i.perimeter_q8 !== want.perimeter_q8) begin
            $display("%0t: perimeter_q8 expected %0d actual %0d", $time,
                     want.perimeter_q8, out_data_i.perimeter_q8);
            errors++;
          end
          if (out_data_i.circularity_q16 !== want.circularity_q16) begin
            $display("%0t: circularity_q16 expected %0d actual %0d", $time,
                     want.circularity_q16, out_data_i.circularity_q16);
            errors++;
          end
          if (out_data_i.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b", $time,
                     want.degenerate, out_data_i.degenerate);
            errors++;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the polygon measurement block.
module tb;
  import papc_pkg::*;

  localparam int CycleLimit = 2000000;

  logic    clk_i = 0;
  logic    rst_ni = 0;
  logic    in_valid = 0;
  logic    in_stall;
  vertex_t in_data = '0;
  logic    out_valid;
  logic    out_stall = 0;
  result_t out_data;
  int      errors;
  int      pending;
  int      cycles = 0;
  bit      no_idle = 0;
  int      stall_burst = 0;

  always #5 clk_i = ~clk_i;

  polygon_area_perimeter_circularity dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  polygon_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Runaway guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls: short random ones plus occasional long bursts.
  always @(posedge clk_i) begin
    if (no_idle || !rst_ni) begin
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_burst <= $urandom_range(10, 60);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // Sends one vertex beat, then an optional gap.
  task automatic send(input logic [11:0] x, input logic [11:0] y, input bit last);
    int r;
    in_valid <= 1'b1;
    in_data  <= '{vertex_x: x, vertex_y: y, last_vertex: last};
    do @(posedge clk_i); while (in_stall);
    r = $urandom_range(0, 99);
    if (!no_idle && r >= 55) begin
      in_valid <= 1'b0;
      if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk_i);
      else repeat ($urandom_range(10, 60)) @(posedge clk_i);
    end
  endtask

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 12'($urandom_range(0, 4095));
      1: return 12'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
      default: return 12'($urandom_range(0, 4095) & 12'hF0F);
    endcase
  endfunction

  // Random polygon; some are collinear so the area vanishes.
  task automatic random_polygon();
    int          n;
    int          r;
    bit          line;
    logic [11:0] x;
    logic [11:0] y;
    r = $urandom_range(0, 99);
    n = (r < 5) ? 1 : (r < 10) ? 2 : (r < 90) ? $urandom_range(3, 8) : $urandom_range(9, 30);
    line = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      x = pick_coord();
      y = line ? x : pick_coord();
      send(x, y, i == n - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lone vertex, out-and-back pair, extreme square, 3-4-5
    // triangle, collinear points, tiny triangle.
    send(12'h7FF, 12'h800, 1);
    send(12'h800, 12'h800, 0); send(12'h7FF, 12'h7FF, 1);
    send(12'h800, 12'h800, 0); send(12'h7FF, 12'h800, 0);
    send(12'h7FF, 12'h7FF, 0); send(12'h800, 12'h7FF, 1);
    send(12'd0, 12'd0, 0); send(12'd3, 12'd0, 0); send(12'd0, 12'd4, 1);
    send(12'd1, 12'd1, 0); send(12'd5, 12'd5, 0); send(12'hFFD, 12'hFFD, 1);
    send(12'd0, 12'd0, 0); send(12'd1, 12'd0, 0); send(12'd0, 12'd1, 1);

    // Hold off until every result is in.
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // Square walked several times: the area saturates.
    for (int i = 0; i < 40; i++) begin
      case (i % 4)
        0: send(12'h800, 12'h800, 0);
        1: send(12'h7FF, 12'h800, 0);
        2: send(12'h7FF, 12'h7FF, 0);
        default: send(12'h800, 12'h7FF, i == 39);
      endcase
    end

    // Random polygons, with stretches free of idling.
    sent = 0;
    while (sent < 85) begin
      no_idle <= ($urandom_range(0, 9) == 0);
      random_polygon();
      sent++;
      if (sent == 42) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
    no_idle <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> polygon_area_perimeter_circularity.f
+incdir+rtl/core
rtl/core/papc_pkg.sv
rtl/core/papc_dp.sv
rtl/core/papc_ctrl.sv
rtl/core/polygon_area_perimeter_circularity.sv
tb/polygon_checker.sv
tb/tb.sv
